FILE: design/scc_pkg.sv
// ----------------------------------------------------------------------------
// scc_pkg
// Shared types and constants of the swept circle collision block.
// ----------------------------------------------------------------------------
`default_nettype none

package scc_pkg;

    localparam int POS_W  = 24;
    localparam int SIZE_W = 23;
    localparam int DIFF_W = POS_W + 1;   // difference of two positions
    localparam int SUM_W  = POS_W + 2;   // sum of two motions
    localparam int RAD_W  = SIZE_W + 1;  // doubled radius sum
    localparam int QNUM_W = SUM_W + 1;   // twice the larger motion magnitude
    localparam int ITEM_W = 8 * POS_W + 4 * SIZE_W;
    localparam int IN_TDATA_W  = ((ITEM_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = 8;

    // packed from the top bit down, so a_now_x lands in the lowest bits
    typedef struct packed {
        logic [SIZE_W-1:0]        b_height;
        logic [SIZE_W-1:0]        b_width;
        logic signed [POS_W-1:0]  b_prev_y;
        logic signed [POS_W-1:0]  b_prev_x;
        logic signed [POS_W-1:0]  b_now_y;
        logic signed [POS_W-1:0]  b_now_x;
        logic [SIZE_W-1:0]        a_height;
        logic [SIZE_W-1:0]        a_width;
        logic signed [POS_W-1:0]  a_prev_y;
        logic signed [POS_W-1:0]  a_prev_x;
        logic signed [POS_W-1:0]  a_now_y;
        logic signed [POS_W-1:0]  a_now_x;
    } t_item;

    typedef struct packed {
        logic load;        // capture a new transaction
        logic square;      // register the squares
        logic qdiv_start;  // start the substep count division
        logic mdiv_start;  // latch n, start the four delta divisions
        logic step;        // advance both objects by one substep
        logic diff;        // register the centre differences
    } t_cmd;

    typedef struct packed {
        logic zero_rad;    // radius sum is zero
        logic overlap;     // circles overlap for the registered squares
        logic small_move;  // motion too small to need substeps
        logic qdiv_busy;
        logic mdiv_busy;
        logic last_step;   // all substeps taken
        logic clamped;     // substep count saturated
    } t_status;

    typedef enum logic [7:0] {
        ST_IDLE = 8'b0000_0001,
        ST_SQ   = 8'b0000_0010,
        ST_CMP  = 8'b0000_0100,
        ST_QDIV = 8'b0000_1000,
        ST_MDIV = 8'b0001_0000,
        ST_STEP = 8'b0010_0000,
        ST_DIFF = 8'b0100_0000,
        ST_DONE = 8'b1000_0000
    } t_state;

endpackage

`default_nettype wire

FILE: design/scc_div.sv
// ----------------------------------------------------------------------------
// scc_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module scc_div #(
    parameter int NW = 27,
    parameter int DW = 24
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [NW-1:0] i_num,
    input  wire logic [DW-1:0] i_den,
    output logic               o_busy,
    output logic [NW-1:0]      o_quo
);

    localparam int CNT_W = $clog2(NW + 1);

    logic [NW-1:0]    r_num;
    logic [DW-1:0]    r_rem;
    logic [DW-1:0]    r_den;
    logic [CNT_W-1:0] r_cnt;

    logic [DW:0] w_sh;
    logic [DW:0] w_dif;
    logic        w_ge;

    assign w_sh  = {r_rem, r_num[NW-1]};
    assign w_ge  = w_sh >= {1'b0, r_den};
    assign w_dif = w_sh - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CNT_W'(NW);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    // quotient bits shift in where the numerator bits leave
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_cnt != '0) begin
            r_num <= {r_num[NW-2:0], w_ge};
            r_rem <= w_ge ? w_dif[DW-1:0] : w_sh[DW-1:0];
        end
    end

    assign o_busy = r_cnt != '0;
    assign o_quo  = r_num;

endmodule

`default_nettype wire

FILE: design/scc_dp.sv
// ----------------------------------------------------------------------------
// scc_dp
// Datapath: squares and overlap compare, dividers, substep positions.
// ----------------------------------------------------------------------------
`default_nettype none

module scc_dp #(
    parameter int MAX_STEPS = 64
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire scc_pkg::t_item   i_item,
    input  wire scc_pkg::t_cmd    i_cmd,
    output scc_pkg::t_status      o_status
);

    localparam int CW = $clog2(MAX_STEPS + 1);
    localparam int PW = scc_pkg::POS_W;
    localparam int DF = scc_pkg::DIFF_W;
    localparam int SW = scc_pkg::SUM_W;
    localparam int RW = scc_pkg::RAD_W;
    localparam int QW = scc_pkg::QNUM_W;

    // captured transaction
    logic signed [PW-1:0] r_pa_x, r_pa_y, r_pb_x, r_pb_y;
    logic signed [DF-1:0] r_ma_x, r_ma_y, r_mb_x, r_mb_y;
    logic [SW-1:0]        r_mx, r_my;
    logic [RW-1:0]        r_s;
    logic signed [DF-1:0] r_dx, r_dy;
    logic [2*DF-1:0]      r_sqx, r_sqy;
    logic [2*RW-1:0]      r_ss;
    logic signed [DF-1:0] w_da_x, w_da_y, w_db_x, w_db_y;
    logic [CW-1:0]        r_n, r_k;
    logic                 r_clamped;

    // input side arithmetic
    logic [scc_pkg::SIZE_W-1:0] w_amax, w_bmax;
    logic signed [DF-1:0]       w_ma_x, w_ma_y, w_mb_x, w_mb_y;
    logic signed [SW-1:0]       w_sx, w_sy;

    assign w_amax = (i_item.a_width > i_item.a_height) ? i_item.a_width : i_item.a_height;
    assign w_bmax = (i_item.b_width > i_item.b_height) ? i_item.b_width : i_item.b_height;
    assign w_ma_x = DF'(i_item.a_now_x) - DF'(i_item.a_prev_x);
    assign w_ma_y = DF'(i_item.a_now_y) - DF'(i_item.a_prev_y);
    assign w_mb_x = DF'(i_item.b_now_x) - DF'(i_item.b_prev_x);
    assign w_mb_y = DF'(i_item.b_now_y) - DF'(i_item.b_prev_y);
    assign w_sx   = SW'(w_ma_x) + SW'(w_mb_x);
    assign w_sy   = SW'(w_ma_y) + SW'(w_mb_y);

    // divider wiring
    logic [QW-1:0] w_qnum, w_q;
    logic          w_qbusy;
    logic          w_clamp;
    logic [CW-1:0] w_n;
    logic [DF-1:0] w_mag_ax, w_mag_ay, w_mag_bx, w_mag_by;
    logic [DF-1:0] w_quo_ax, w_quo_ay, w_quo_bx, w_quo_by;
    logic [3:0]    w_mbusy;

    assign w_qnum  = (r_mx > r_my) ? {r_mx, 1'b0} : {r_my, 1'b0};
    assign w_clamp = w_q >= QW'(MAX_STEPS);
    assign w_n     = w_clamp ? CW'(MAX_STEPS) : CW'(w_q + QW'(1));

    assign w_mag_ax = r_ma_x[DF-1] ? DF'(-r_ma_x) : DF'(r_ma_x);
    assign w_mag_ay = r_ma_y[DF-1] ? DF'(-r_ma_y) : DF'(r_ma_y);
    assign w_mag_bx = r_mb_x[DF-1] ? DF'(-r_mb_x) : DF'(r_mb_x);
    assign w_mag_by = r_mb_y[DF-1] ? DF'(-r_mb_y) : DF'(r_mb_y);

    scc_div #(.NW(QW), .DW(RW)) u_qdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.qdiv_start),
        .i_num   (w_qnum),
        .i_den   (r_s),
        .o_busy  (w_qbusy),
        .o_quo   (w_q)
    );

    scc_div #(.NW(DF), .DW(CW)) u_div_ax (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_cmd.mdiv_start),
        .i_num(w_mag_ax), .i_den(w_n), .o_busy(w_mbusy[0]), .o_quo(w_quo_ax)
    );
    scc_div #(.NW(DF), .DW(CW)) u_div_ay (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_cmd.mdiv_start),
        .i_num(w_mag_ay), .i_den(w_n), .o_busy(w_mbusy[1]), .o_quo(w_quo_ay)
    );
    scc_div #(.NW(DF), .DW(CW)) u_div_bx (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_cmd.mdiv_start),
        .i_num(w_mag_bx), .i_den(w_n), .o_busy(w_mbusy[2]), .o_quo(w_quo_bx)
    );
    scc_div #(.NW(DF), .DW(CW)) u_div_by (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_cmd.mdiv_start),
        .i_num(w_mag_by), .i_den(w_n), .o_busy(w_mbusy[3]), .o_quo(w_quo_by)
    );

    // deltas truncate toward zero: divide magnitudes, put the sign back
    always_comb begin
        w_da_x = r_ma_x[DF-1] ? -$signed(w_quo_ax) : $signed(w_quo_ax);
        w_da_y = r_ma_y[DF-1] ? -$signed(w_quo_ay) : $signed(w_quo_ay);
        w_db_x = r_mb_x[DF-1] ? -$signed(w_quo_bx) : $signed(w_quo_bx);
        w_db_y = r_mb_y[DF-1] ? -$signed(w_quo_by) : $signed(w_quo_by);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_pa_x <= i_item.a_prev_x;
            r_pa_y <= i_item.a_prev_y;
            r_pb_x <= i_item.b_prev_x;
            r_pb_y <= i_item.b_prev_y;
            r_ma_x <= w_ma_x;
            r_ma_y <= w_ma_y;
            r_mb_x <= w_mb_x;
            r_mb_y <= w_mb_y;
            r_mx   <= w_sx[SW-1] ? SW'(-w_sx) : SW'(w_sx);
            r_my   <= w_sy[SW-1] ? SW'(-w_sy) : SW'(w_sy);
            r_s    <= RW'(w_amax) + RW'(w_bmax);
            r_dx   <= DF'(i_item.a_now_x) - DF'(i_item.b_now_x);
            r_dy   <= DF'(i_item.a_now_y) - DF'(i_item.b_now_y);
        end else begin
            if (i_cmd.step) begin
                // positions stay between previous and current, so no overflow
                r_pa_x <= r_pa_x + w_da_x[PW-1:0];
                r_pa_y <= r_pa_y + w_da_y[PW-1:0];
                r_pb_x <= r_pb_x + w_db_x[PW-1:0];
                r_pb_y <= r_pb_y + w_db_y[PW-1:0];
            end
            if (i_cmd.diff) begin
                r_dx <= DF'(r_pa_x) - DF'(r_pb_x);
                r_dy <= DF'(r_pa_y) - DF'(r_pb_y);
            end
        end
        if (i_cmd.square) begin
            r_sqx <= r_dx * r_dx;
            r_sqy <= r_dy * r_dy;
            r_ss  <= r_s * r_s;
        end
        if (i_cmd.mdiv_start) begin
            r_n <= w_n;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k       <= '0;
            r_clamped <= 1'b0;
        end else if (i_cmd.load) begin
            r_k       <= '0;
            r_clamped <= 1'b0;
        end else begin
            if (i_cmd.mdiv_start) begin
                r_clamped <= w_clamp;
            end
            if (i_cmd.step) begin
                r_k <= r_k + 1'b1;
            end
        end
    end

    // lengths are doubled: (2dx)^2 + (2dy)^2 < s^2
    logic [2*DF:0] w_sqsum;
    assign w_sqsum = (2*DF+1)'(r_sqx) + (2*DF+1)'(r_sqy);

    always_comb begin
        o_status            = '0;
        o_status.zero_rad   = r_s == '0;
        o_status.overlap    = {w_sqsum, 2'b00} < (2*DF+3)'(r_ss);
        o_status.small_move = ({r_mx, 1'b0} < QW'(r_s)) && ({r_my, 1'b0} < QW'(r_s));
        o_status.qdiv_busy  = w_qbusy;
        o_status.mdiv_busy  = w_mbusy != '0;
        o_status.last_step  = r_k == r_n;
        o_status.clamped    = r_clamped;
    end

endmodule

`default_nettype wire

FILE: design/scc_ctrl.sv
// ----------------------------------------------------------------------------
// scc_ctrl
// Controller: sequences the datapath and holds the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module scc_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output logic                   o_hit,
    output logic                   o_clamped,
    input  wire scc_pkg::t_status  i_status,
    output scc_pkg::t_cmd          o_cmd
);

    scc_pkg::t_state r_state, n_state;
    logic r_sub, n_sub;
    logic r_hit, n_hit;
    logic r_out_valid, r_out_hit, r_out_clamped;
    logic w_out_free;

    assign w_out_free = !r_out_valid || i_out_ready;
    assign o_in_ready = r_state == scc_pkg::ST_IDLE;

    always_comb begin
        n_state = r_state;
        n_sub   = r_sub;
        n_hit   = r_hit;
        o_cmd   = '0;
        case (r_state)
            scc_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_sub      = 1'b0;
                    n_hit      = 1'b0;
                    n_state    = scc_pkg::ST_SQ;
                end
            end
            scc_pkg::ST_SQ: begin
                o_cmd.square = 1'b1;
                n_state      = scc_pkg::ST_CMP;
            end
            scc_pkg::ST_CMP: begin
                if (i_status.zero_rad) begin
                    n_state = scc_pkg::ST_DONE;
                end else if (i_status.overlap) begin
                    n_hit   = 1'b1;
                    n_state = scc_pkg::ST_DONE;
                end else if (!r_sub) begin
                    if (i_status.small_move) begin
                        n_state = scc_pkg::ST_DONE;
                    end else begin
                        o_cmd.qdiv_start = 1'b1;
                        n_state          = scc_pkg::ST_QDIV;
                    end
                end else if (i_status.last_step) begin
                    n_state = scc_pkg::ST_DONE;
                end else begin
                    n_state = scc_pkg::ST_STEP;
                end
            end
            scc_pkg::ST_QDIV: begin
                if (!i_status.qdiv_busy) begin
                    o_cmd.mdiv_start = 1'b1;
                    n_state          = scc_pkg::ST_MDIV;
                end
            end
            scc_pkg::ST_MDIV: begin
                if (!i_status.mdiv_busy) begin
                    n_sub   = 1'b1;
                    n_state = scc_pkg::ST_STEP;
                end
            end
            scc_pkg::ST_STEP: begin
                o_cmd.step = 1'b1;
                n_state    = scc_pkg::ST_DIFF;
            end
            scc_pkg::ST_DIFF: begin
                o_cmd.diff = 1'b1;
                n_state    = scc_pkg::ST_SQ;
            end
            scc_pkg::ST_DONE: begin
                if (w_out_free) begin
                    n_state = scc_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = scc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= scc_pkg::ST_IDLE;
            r_sub       <= 1'b0;
            r_hit       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_sub   <= n_sub;
            r_hit   <= n_hit;
            if (r_state == scc_pkg::ST_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == scc_pkg::ST_DONE && w_out_free) begin
            r_out_hit     <= r_hit;
            r_out_clamped <= i_status.clamped;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_hit       = r_out_hit;
    assign o_clamped   = r_out_clamped;

endmodule

`default_nettype wire

FILE: design/swept_circle_collision_test.sv
// ----------------------------------------------------------------------------
// swept_circle_collision_test
// Swept bounding-circle hit test of two moving objects, with substepping.
// ----------------------------------------------------------------------------
//  channel   dir  handshake                     payload
//  s_axis    in   s_axis_tvalid/s_axis_tready   positions and sizes of a, b
//  m_axis    out  m_axis_tvalid/m_axis_tready   hit, steps_clamped
//
// One transaction at a time. A direct hit or miss needs only the square
// and compare states; a swept test adds the serial substep count divider,
// the four delta dividers and, for each of at most MAX_STEPS substeps, a
// loop of step, difference, square and compare. The serial dividers and the
// per-substep loop set the run time. Synchronous active-low reset idles the
// controller and empties the result register. A waiting result is held in
// the output register; a new transaction is taken while it waits.
// ----------------------------------------------------------------------------
`default_nettype none

module swept_circle_collision_test #(
    parameter int MAX_STEPS = 64
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // a_now_x, a_now_y, a_prev_x, a_prev_y, a_width, a_height,
    // b_now_x, b_now_y, b_prev_x, b_prev_y, b_width, b_height, zero pad
    input  wire logic [scc_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // hit, steps_clamped, zero pad
    output logic [scc_pkg::OUT_TDATA_W-1:0]        m_axis_tdata
);

    scc_pkg::t_item   w_item;
    scc_pkg::t_cmd    w_cmd;
    scc_pkg::t_status w_status;
    logic             w_hit, w_clamped;

    assign w_item = s_axis_tdata[scc_pkg::ITEM_W-1:0];

    scc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_hit       (w_hit),
        .o_clamped   (w_clamped),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    scc_dp #(.MAX_STEPS(MAX_STEPS)) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (w_item),
        .i_cmd    (w_cmd),
        .o_status (w_status)
    );

    assign m_axis_tdata = {(scc_pkg::OUT_TDATA_W-2)'(0), w_clamped, w_hit};

endmodule

`default_nettype wire

FILE: tb/tb_swept_circle_collision_test.sv
// ----------------------------------------------------------------------------
// tb_swept_circle_collision_test
// Checks the swept circle hit test against a behavioural predictor, with
// directed corner cases followed by random object pairs under varied idling.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_swept_circle_collision_test;

    localparam int MAX_STEPS = 64;
    localparam int N_RANDOM  = 1400;
    localparam int PW        = scc_pkg::POS_W;
    localparam int SZ        = scc_pkg::SIZE_W;

    typedef struct packed {
        logic hit;
        logic clamped;
    } t_res;

    typedef struct {
        scc_pkg::t_item item;
        logic  known;   // expected result typed into the table
        t_res  res;
    } t_vec;

    logic                             i_clk = 1'b0;
    logic                             i_rst_n = 1'b0;
    logic                             s_axis_tvalid = 1'b0;
    wire                              s_axis_tready;
    logic [scc_pkg::IN_TDATA_W-1:0]   s_axis_tdata = '0;
    wire                              m_axis_tvalid;
    logic                             m_axis_tready = 1'b0;
    wire  [scc_pkg::OUT_TDATA_W-1:0]  m_axis_tdata;

    t_res  hits_due[$];
    int    n_mismatch = 0;
    int    src_idle = 0;     // percent
    int    snk_stall = 0;    // percent
    t_vec  vecs[$];

    swept_circle_collision_test #(.MAX_STEPS(MAX_STEPS)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic longint mag(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic bit circles_touch(longint dx, longint dy, longint s);
        longint ax, ay;
        ax = mag(dx) * 2;
        ay = mag(dy) * 2;
        return ax * ax + ay * ay < s * s;
    endfunction

    function automatic t_res predict_hit(scc_pkg::t_item it);
        longint anx, any_, apx, apy, bnx, bny, bpx, bpy, s;
        longint ma_x, ma_y, mb_x, mb_y, mx, my, q;
        longint dax, day, dbx, dby, pax, pay, pbx, pby;
        t_res r;
        anx = longint'(it.a_now_x);  any_ = longint'(it.a_now_y);
        apx = longint'(it.a_prev_x); apy = longint'(it.a_prev_y);
        bnx = longint'(it.b_now_x);  bny = longint'(it.b_now_y);
        bpx = longint'(it.b_prev_x); bpy = longint'(it.b_prev_y);
        s = longint'(it.a_width > it.a_height ? it.a_width : it.a_height)
          + longint'(it.b_width > it.b_height ? it.b_width : it.b_height);
        r = '0;
        if (s == 0) return r;
        if (circles_touch(anx - bnx, any_ - bny, s)) begin
            r.hit = 1'b1;
            return r;
        end
        ma_x = anx - apx; ma_y = any_ - apy;
        mb_x = bnx - bpx; mb_y = bny - bpy;
        mx = mag(ma_x + mb_x);
        my = mag(ma_y + mb_y);
        if (mx * 2 < s && my * 2 < s) return r;
        q = ((mx > my ? mx : my) * 2) / s + 1;
        if (q > MAX_STEPS) begin
            q = MAX_STEPS;
            r.clamped = 1'b1;
        end
        // SV division truncates toward zero, as the substep deltas require
        dax = ma_x / q; day = ma_y / q; dbx = mb_x / q; dby = mb_y / q;
        pax = apx; pay = apy; pbx = bpx; pby = bpy;
        for (longint k = 0; k < q; k++) begin
            pax += dax; pay += day; pbx += dbx; pby += dby;
            if (circles_touch(pax - pbx, pay - pby, s)) begin
                r.hit = 1'b1;
                break;
            end
        end
        return r;
    endfunction

    function automatic scc_pkg::t_item rand_item();
        scc_pkg::t_item it;
        int    spread;
        int    size_max;
        it = scc_pkg::t_item'(scc_pkg::ITEM_W'({$urandom, $urandom, $urandom,
                      $urandom, $urandom, $urandom, $urandom, $urandom, $urandom}));
        case ($urandom_range(0, 5))
            0: ; // fully random noise
            1, 2, 3: begin
                // nearby objects, moving, so the swept path matters
                spread = 1 << $urandom_range(6, 22);
                size_max = 1 << $urandom_range(2, 20);
                it.a_now_x  = PW'($signed($urandom_range(0, 2*spread)) - spread);
                it.a_now_y  = PW'($signed($urandom_range(0, 2*spread)) - spread);
                it.b_now_x  = PW'($signed($urandom_range(0, 2*spread)) - spread);
                it.b_now_y  = PW'($signed($urandom_range(0, 2*spread)) - spread);
                it.a_prev_x = PW'($signed($urandom_range(0, 2*spread)) - spread);
                it.a_prev_y = PW'($signed($urandom_range(0, 2*spread)) - spread);
                it.b_prev_x = PW'($signed($urandom_range(0, 2*spread)) - spread);
                it.b_prev_y = PW'($signed($urandom_range(0, 2*spread)) - spread);
                it.a_width  = SZ'($urandom_range(0, size_max));
                it.a_height = SZ'($urandom_range(0, size_max));
                it.b_width  = SZ'($urandom_range(0, size_max));
                it.b_height = SZ'($urandom_range(0, size_max));
            end
            4: begin
                // tiny objects crossing far: clamped substep count
                it.a_width  = SZ'($urandom_range(0, 15));
                it.a_height = SZ'($urandom_range(0, 15));
                it.b_width  = SZ'($urandom_range(0, 15));
                it.b_height = SZ'($urandom_range(0, 15));
            end
            default: begin
                // passing through each other between frames
                it.b_prev_x = it.a_now_x;  it.b_prev_y = it.a_now_y;
                it.b_now_x  = it.a_prev_x; it.b_now_y  = it.a_prev_y;
                it.a_width  = SZ'($urandom_range(0, 1 << 14));
                it.b_height = SZ'($urandom_range(0, 1 << 14));
                it.a_height = '0; it.b_width = '0;
            end
        endcase
        return it;
    endfunction

    function automatic scc_pkg::t_item mk(int anx, int any_, int apx, int apy, int aw, int ah,
                                          int bnx, int bny, int bpx, int bpy, int bw, int bh);
        scc_pkg::t_item it;
        it.a_now_x = PW'(anx); it.a_now_y = PW'(any_);
        it.a_prev_x = PW'(apx); it.a_prev_y = PW'(apy);
        it.a_width = SZ'(aw);  it.a_height = SZ'(ah);
        it.b_now_x = PW'(bnx); it.b_now_y = PW'(bny);
        it.b_prev_x = PW'(bpx); it.b_prev_y = PW'(bpy);
        it.b_width = SZ'(bw);  it.b_height = SZ'(bh);
        return it;
    endfunction

    task automatic add_vec(scc_pkg::t_item it, logic known, logic h, logic c);
        t_vec v;
        v.item = it; v.known = known; v.res = '{hit: h, clamped: c};
        vecs.push_back(v);
    endtask

    task automatic send_item(scc_pkg::t_item it, t_res want);
        while (src_idle > 0 && $urandom_range(0, 99) < src_idle) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= scc_pkg::IN_TDATA_W'(it);
        hits_due.push_back(want);
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    // sender goes quiet until every expected result has come back
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (hits_due.size() != 0) @(posedge i_clk);
    endtask

    // result side
    always @(posedge i_clk) begin
        t_res got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = '{hit: m_axis_tdata[0], clamped: m_axis_tdata[1]};
            if (hits_due.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= 10) $display("unexpected result transaction %b", got);
            end else begin
                want = hits_due.pop_front();
                if (got !== want || m_axis_tdata[7:2] !== '0) begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display("mismatch: expected hit=%b clamped=%b, got tdata=%b",
                                 want.hit, want.clamped, m_axis_tdata);
                end
            end
        end
        m_axis_tready <= !(snk_stall > 0 && $urandom_range(0, 99) < snk_stall);
    end

    initial begin
        #8_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        scc_pkg::t_item it;
        t_res  want;
        int    drain;
        // zero radius sum
        add_vec(mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, 0, 0);
        // coincident centres, overlap now
        add_vec(mk(0, 0, 0, 0, 256, 0, 0, 0, 0, 0, 0, 0), 1, 1, 0);
        // far apart, still: small motion miss
        add_vec(mk(-8388608, -8388608, -8388608, -8388608, 1, 1,
                   8388607, 8388607, 8388607, 8388607, 1, 1), 1, 0, 0);
        // tiny circles crossing the whole range: clamped
        add_vec(mk(8388607, 0, -8388608, 0, 1, 0,
                   8388607, 1000, -8388608, 1000, 0, 1), 1, 0, 1);
        // largest sizes on extreme corners
        add_vec(mk(-8388608, 8388607, 0, 0, 8388607, 8388607,
                   8388607, -8388608, 0, 0, 8388607, 8388607), 0, 0, 0);
        // tunnelling through, caught by substeps
        add_vec(mk(5000, 0, -5000, 0, 256, 256,
                   0, 0, 0, 0, 256, 256), 1, 1, 0);
        // just touching boundary (equal distance is not a hit)
        add_vec(mk(0, 0, 0, 0, 100, 100, 100, 0, 100, 0, 100, 100), 1, 0, 0);
        add_vec(mk(0, 0, 0, 0, 100, 100, 99, 0, 99, 0, 100, 100), 1, 1, 0);
        // motion above the radius sum triggers substeps; negative deltas
        add_vec(mk(-50, 0, 0, 0, 10, 0, 500, 0, 500, 0, 0, 10), 0, 0, 0);
        add_vec(mk(-7, -3, 5, 9, 3, 2, 40, -40, 40, -40, 1, 4), 0, 0, 0);
        add_vec(mk(1, -1, -1, 1, 0, 1, 0, 0, 0, 0, 0, 0), 0, 0, 0);
        add_vec(mk(-1, -1, -1, -1, 8388607, 0, -1, -1, -1, -1, 0, 8388607),
                1, 1, 0);

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (vecs[i]) begin
            want = vecs[i].known ? vecs[i].res : predict_hit(vecs[i].item);
            send_item(vecs[i].item, want);
        end

        for (int i = 0; i < N_RANDOM; i++) begin
            case ((i * 5) / N_RANDOM)
                0: begin src_idle = 0;  snk_stall = 0;  end
                1: begin src_idle = 71; snk_stall = 0;  end
                2: begin src_idle = 0;  snk_stall = 71; end
                3: begin src_idle = 20; snk_stall = 20; end
                default: begin
                    src_idle = ($urandom_range(0, 1)) ? 0 : 50;
                    snk_stall = ($urandom_range(0, 1)) ? 0 : 50;
                end
            endcase
            // let the pipeline drain completely once in a while
            if (i % 300 == 150)
                wait_drained();
            it = rand_item();
            send_item(it, predict_hit(it));
        end

        wait_drained();
        drain = 0;
        while (drain < 400) begin
            @(posedge i_clk);
            drain++;
        end
        if (n_mismatch == 0 && hits_due.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
